### rtl/cle_pkg.sv
// Shared constants and types for the console line editor.
package cle_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 128;

    localparam logic [1:0] CMD_KEY   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [2:0] KIND_SENT  = 3'd0;
    localparam logic [2:0] KIND_ERASE = 3'd1;
    localparam logic [2:0] KIND_CHAR  = 3'd2;
    localparam logic [2:0] KIND_NONE  = 3'd3;
    localparam logic [2:0] KIND_EOF   = 3'd4;

    localparam logic [7:0] KEY_NUL    = 8'h00;
    localparam logic [7:0] KEY_CTRL_D = 8'h04;
    localparam logic [7:0] KEY_CTRL_H = 8'h08;
    localparam logic [7:0] KEY_LF     = 8'h0a;
    localparam logic [7:0] KEY_CR     = 8'h0d;
    localparam logic [7:0] KEY_CTRL_P = 8'h10;
    localparam logic [7:0] KEY_CTRL_U = 8'h15;
    localparam logic [7:0] KEY_DEL    = 8'h7f;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_res;
        logic [7:0] erase_count;
        logic       last;
    } result_t;

endpackage

### rtl/console_line_editor.sv
// Canonical-mode console line editor: ring buffer in one RAM plus a two-word result queue.
//
// Each input word is handled in two steps: the accept edge reads the line RAM at the read
// pointer, and the execute step applies the edit, writes the RAM and pushes up to two
// result words (newline echoes as CR then LF) into a two-entry output queue. A new word
// is accepted while results are still waiting to be taken, but not while the last word is
// still in execute; the execute step holds only while the queue lacks room for its results.
module console_line_editor #(
    parameter int BUFFER_DEPTH = cle_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] data,
    input  logic       first_of_read,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [2:0] kind,
    output logic [7:0] byte_res,
    output logic [7:0] erase_count,
    output logic       last
);
    import cle_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int IW = $clog2(2 * BUFFER_DEPTH);
    localparam logic [IW:0]   SPAN    = (IW + 1)'(2 * BUFFER_DEPTH);
    localparam logic [IW-1:0] DEPTH_I = IW'(BUFFER_DEPTH);
    localparam logic [IW-1:0] DEPTH_M = IW'(BUFFER_DEPTH - 1);
    localparam logic [IW-1:0] LAST_I  = IW'(2 * BUFFER_DEPTH - 1);

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] v);
        logic [IW-1:0] a;
        a = (v >= DEPTH_I) ? v - DEPTH_I : v;
        return a[AW-1:0];
    endfunction

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] v);
        return (v == LAST_I) ? '0 : v + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] v);
        return (v == '0) ? LAST_I : v - 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dist(input logic [IW-1:0] a,
                                               input logic [IW-1:0] b);
        logic [IW:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[IW])
        begin
            d = d + SPAN;
        end
        return d[IW-1:0];
    endfunction

    function automatic logic [7:0] sat8(input logic [IW-1:0] v);
        logic [IW+8:0] w;
        w = (IW + 9)'(v);
        return (w > (IW + 9)'(255)) ? 8'hff : w[7:0];
    endfunction

    logic [7:0]    mem [BUFFER_DEPTH];

    logic [IW-1:0] read_reg, read_next;
    logic [IW-1:0] commit_reg, commit_next;
    logic [IW-1:0] edit_reg, edit_next;
    logic          busy_reg;
    logic [1:0]    cmd_reg;
    logic [7:0]    data_reg;
    logic          first_reg;
    logic [7:0]    rdata_reg;
    result_t       slot_reg [2];
    result_t       slot_next [2];
    logic [1:0]    cnt_reg, cnt_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_byte;
    logic          echo_en;
    logic [7:0]    echo_byte;
    logic [1:0]    need;
    result_t       r0, r1;
    logic          pop, accept, exec_fire;
    logic [1:0]    cnt_pop;
    logic [2:0]    room_sum;
    logic [IW-1:0] fill;

    assign item_ready  = !busy_reg;
    assign accept      = item_valid && item_ready;
    assign res_valid   = (cnt_reg != 2'd0);
    assign pop         = res_valid && res_ready;
    assign kind        = slot_reg[0].kind;
    assign byte_res    = slot_reg[0].byte_res;
    assign erase_count = slot_reg[0].erase_count;
    assign last        = slot_reg[0].last;

    assign cnt_pop   = cnt_reg - {1'b0, pop};
    assign room_sum  = {1'b0, cnt_pop} + {1'b0, need};
    assign exec_fire = busy_reg && (room_sum <= 3'd2);
    assign fill      = idx_dist(edit_reg, read_reg);

    always_comb
    begin
        read_next   = read_reg;
        commit_next = commit_reg;
        edit_next   = edit_reg;
        wr_en       = 1'b0;
        wr_addr     = addr_of(edit_reg);
        wr_byte     = data_reg;
        echo_en     = 1'b0;
        echo_byte   = data_reg;
        need        = 2'd0;
        r0          = '0;
        r1          = '0;
        case (cmd_reg)
            CMD_KEY:
            begin
                if (data_reg == KEY_CTRL_P)
                begin
                    need = 2'd0;
                end
                else if (data_reg == KEY_CTRL_U)
                begin
                    edit_next = commit_reg;
                    need      = 2'd1;
                    r0        = '{kind: KIND_ERASE, byte_res: 8'h00,
                                  erase_count: sat8(idx_dist(edit_reg, commit_reg)),
                                  last: 1'b1};
                end
                else if (data_reg == KEY_CTRL_H || data_reg == KEY_DEL)
                begin
                    need = 2'd1;
                    r0   = '{kind: KIND_ERASE, byte_res: 8'h00, erase_count: 8'h00,
                             last: 1'b1};
                    if (edit_reg != commit_reg)
                    begin
                        edit_next      = idx_dec(edit_reg);
                        r0.erase_count = 8'h01;
                    end
                end
                else if (data_reg != KEY_NUL && fill < DEPTH_I)
                begin
                    wr_byte   = (data_reg == KEY_CR) ? KEY_LF : data_reg;
                    wr_en     = 1'b1;
                    edit_next = idx_inc(edit_reg);
                    echo_en   = 1'b1;
                    echo_byte = wr_byte;
                    if (wr_byte == KEY_LF || wr_byte == KEY_CTRL_D || fill == DEPTH_M)
                    begin
                        commit_next = idx_inc(edit_reg);
                    end
                end
            end
            CMD_READ:
            begin
                need = 2'd1;
                if (read_reg == commit_reg)
                begin
                    r0 = '{kind: KIND_NONE, byte_res: 8'h00, erase_count: 8'h00,
                           last: 1'b1};
                end
                else if (rdata_reg == KEY_CTRL_D)
                begin
                    r0 = '{kind: KIND_EOF, byte_res: 8'h00, erase_count: 8'h00,
                           last: 1'b1};
                    if (first_reg)
                    begin
                        read_next = idx_inc(read_reg);
                    end
                end
                else
                begin
                    r0 = '{kind: KIND_CHAR, byte_res: rdata_reg, erase_count: 8'h00,
                           last: 1'b1};
                    read_next = idx_inc(read_reg);
                end
            end
            CMD_WRITE:
            begin
                echo_en   = 1'b1;
                echo_byte = data_reg;
            end
            default:
            begin
                need = 2'd0;
            end
        endcase
        if (echo_en)
        begin
            if (echo_byte == KEY_LF)
            begin
                need = 2'd2;
                r0   = '{kind: KIND_SENT, byte_res: KEY_CR, erase_count: 8'h00,
                         last: 1'b0};
                r1   = '{kind: KIND_SENT, byte_res: KEY_LF, erase_count: 8'h00,
                         last: 1'b1};
            end
            else
            begin
                need = 2'd1;
                r0   = '{kind: KIND_SENT, byte_res: echo_byte, erase_count: 8'h00,
                         last: 1'b1};
            end
        end
    end

    // result queue: shift toward the head on pop, then append
    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        cnt_next     = cnt_pop;
        if (pop)
        begin
            slot_next[0] = slot_reg[1];
        end
        if (exec_fire && need != 2'd0)
        begin
            if (cnt_pop == 2'd0)
            begin
                slot_next[0] = r0;
            end
            else
            begin
                slot_next[1] = r0;
            end
            if (need == 2'd2)
            begin
                slot_next[1] = r1;
            end
            cnt_next = 2'(room_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_reg   <= '0;
            commit_reg <= '0;
            edit_reg   <= '0;
            busy_reg   <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (exec_fire)
            begin
                busy_reg <= 1'b0;
            end
            if (exec_fire)
            begin
                read_reg   <= read_next;
                commit_reg <= commit_next;
                edit_reg   <= edit_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            data_reg  <= data;
            first_reg <= first_of_read;
        end
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    // line RAM: read at accept, written on execute
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= mem[addr_of(read_reg)];
        end
        if (exec_fire && wr_en)
        begin
            mem[wr_addr] <= wr_byte;
        end
    end

endmodule
